### design/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg - shared definitions for the audio stutter loop unit
// Holds the default frame and loop sizes, the frame mode codes and the
// command that the control logic hands to the loop store.
// ----------------------------------------------------------------------------
package asl_pkg;

  localparam int unsigned FRAME_SAMPLES_DEF = 48;
  localparam int unsigned LOOP_FRAMES_DEF   = 63;
  localparam int unsigned SAMPLE_W          = 32;
  localparam int unsigned PAIR_W            = 2 * SAMPLE_W;

  // Operating mode of one frame, fixed on its first pair
  typedef enum logic [2:0] {
    MODE_BYPASS = 3'b001,
    MODE_RECORD = 3'b010,
    MODE_LOOP   = 3'b100
  } mode_t;

  // Access to the loop store for one item: at most one of the two is set
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

### design/asl_if.sv
// ----------------------------------------------------------------------------
// asl_if - item channels of the audio stutter loop unit
// Valid/ready channels for the input pair with its enable level and for
// the result pair with its looping flag.
// ----------------------------------------------------------------------------
interface asl_in_if;
  logic                                valid;
  logic                                ready;
  logic                                enable;
  logic signed [asl_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [asl_pkg::SAMPLE_W-1:0] sample_right;

  modport source (output valid, output enable, output sample_left,
                  output sample_right, input ready);
  modport sink   (input valid, input enable, input sample_left,
                  input sample_right, output ready);
endinterface

interface asl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [asl_pkg::SAMPLE_W-1:0] out_left;
  logic signed [asl_pkg::SAMPLE_W-1:0] out_right;
  logic                                looping;

  modport source (output valid, output out_left, output out_right,
                  output looping, input ready);
  modport sink   (input valid, input out_left, input out_right,
                  input looping, output ready);
endinterface

### design/asl_ctrl.sv
// ----------------------------------------------------------------------------
// asl_ctrl - frame and loop control
// Tracks the frame position, samples the enable level at frame start and
// steps the record and play indexes; issues at most one store access per item.
// ----------------------------------------------------------------------------
module asl_ctrl #(
  parameter int unsigned FRAME_SAMPLES = asl_pkg::FRAME_SAMPLES_DEF,
  parameter int unsigned LOOP_DEPTH    = asl_pkg::FRAME_SAMPLES_DEF * asl_pkg::LOOP_FRAMES_DEF,
  parameter int unsigned ADDR_W        = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic                     enable,
  output asl_pkg::mem_cmd_t        cmd,
  output logic [ADDR_W-1:0]        addr
);

  localparam int unsigned POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(FRAME_SAMPLES - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LOOP_DEPTH - 1);

  logic [POS_W-1:0]  frame_position, frame_position_next;
  logic [ADDR_W-1:0] record_index, record_index_next;
  logic [ADDR_W-1:0] play_index, play_index_next;
  logic              is_recording, is_recording_next;
  logic              is_looping, is_looping_next;
  logic              last_enable, last_enable_next;
  asl_pkg::mode_t    frame_mode, frame_mode_next;

  always_comb begin
    frame_position_next = frame_position;
    record_index_next   = record_index;
    play_index_next     = play_index;
    is_recording_next   = is_recording;
    is_looping_next     = is_looping;
    last_enable_next    = last_enable;
    frame_mode_next     = frame_mode;
    cmd                 = '0;
    addr                = play_index;

    // Sample the enable level on the first pair of a frame only
    if (frame_position == '0) begin
      if (enable && !last_enable) begin
        is_recording_next = 1'b1;
        is_looping_next   = 1'b0;
        record_index_next = '0;
        play_index_next   = '0;
      end
      if (!enable) begin
        is_recording_next = 1'b0;
        is_looping_next   = 1'b0;
      end
      last_enable_next = enable;
      if (is_recording_next) begin
        frame_mode_next = asl_pkg::MODE_RECORD;
      end else if (is_looping_next) begin
        frame_mode_next = asl_pkg::MODE_LOOP;
      end else begin
        frame_mode_next = asl_pkg::MODE_BYPASS;
      end
    end

    case (frame_mode_next)
      asl_pkg::MODE_RECORD: begin
        if (is_recording_next) begin
          cmd.wr_en = 1'b1;
          addr      = record_index_next;
          if (record_index_next == LAST_ADDR) begin
            is_recording_next = 1'b0;
            is_looping_next   = 1'b1;
            record_index_next = '0;
          end else begin
            record_index_next = record_index_next + 1'b1;
          end
        end
      end
      asl_pkg::MODE_LOOP: begin
        cmd.rd_en = 1'b1;
        addr      = play_index_next;
        if (play_index_next == LAST_ADDR) begin
          play_index_next = '0;
        end else begin
          play_index_next = play_index_next + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (frame_position == LAST_POS) begin
      frame_position_next = '0;
    end else begin
      frame_position_next = frame_position + 1'b1;
    end

    if (!take) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      record_index   <= '0;
      play_index     <= '0;
      is_recording   <= 1'b0;
      is_looping     <= 1'b0;
      last_enable    <= 1'b0;
      frame_mode     <= asl_pkg::MODE_BYPASS;
    end else if (take) begin
      frame_position <= frame_position_next;
      record_index   <= record_index_next;
      play_index     <= play_index_next;
      is_recording   <= is_recording_next;
      is_looping     <= is_looping_next;
      last_enable    <= last_enable_next;
      frame_mode     <= frame_mode_next;
    end
  end

endmodule

### design/asl_store.sv
// ----------------------------------------------------------------------------
// asl_store - loop store
// Single-port synchronous memory of stereo pairs; read data is registered
// and holds until the next read.
// ----------------------------------------------------------------------------
module asl_store #(
  parameter int unsigned LOOP_DEPTH = asl_pkg::FRAME_SAMPLES_DEF * asl_pkg::LOOP_FRAMES_DEF,
  parameter int unsigned ADDR_W     = 12
) (
  input  logic                         clk,
  input  asl_pkg::mem_cmd_t            cmd,
  input  logic [ADDR_W-1:0]            addr,
  input  logic [asl_pkg::PAIR_W-1:0]   wdata,
  output logic [asl_pkg::PAIR_W-1:0]   rdata
);

  logic [asl_pkg::PAIR_W-1:0] mem [LOOP_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/audio_stutter_loop_unit.sv
// ----------------------------------------------------------------------------
// audio_stutter_loop_unit - stereo stutter loop effect
// Records FRAME_SAMPLES * LOOP_FRAMES pairs on a rising enable, then loops
// them from the next frame on in place of the input until enable drops.
// ----------------------------------------------------------------------------
// A result is shown in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; each item makes at most one
//   access to the one store port (write when recording, read when looping).
// Reset (rst, synchronous): clears frame position, indexes, mode and the
//   output valid; the loop store is not cleared.
// ----------------------------------------------------------------------------
module audio_stutter_loop_unit #(
  parameter int unsigned FRAME_SAMPLES = asl_pkg::FRAME_SAMPLES_DEF,
  parameter int unsigned LOOP_FRAMES   = asl_pkg::LOOP_FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  asl_in_if.sink    din,
  asl_out_if.source dout
);

  localparam int unsigned LOOP_DEPTH = FRAME_SAMPLES * LOOP_FRAMES;
  localparam int unsigned ADDR_W     = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;

  asl_pkg::mem_cmd_t                   cmd;
  logic [ADDR_W-1:0]                   addr;
  logic [asl_pkg::PAIR_W-1:0]          rdata;
  logic                                take;

  // Output register: holds the passed-through pair and the looping flag
  logic                                out_valid;
  logic                                out_looping;
  logic signed [asl_pkg::SAMPLE_W-1:0] out_left_q;
  logic signed [asl_pkg::SAMPLE_W-1:0] out_right_q;

  // Accept a new item whenever the output register is empty or drains now
  assign din.ready = !out_valid || dout.ready;
  assign take      = din.valid && din.ready;

  asl_ctrl #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .LOOP_DEPTH    (LOOP_DEPTH),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .enable (din.enable),
    .cmd    (cmd),
    .addr   (addr)
  );

  // Store left in the upper half, right in the lower half
  asl_store #(
    .LOOP_DEPTH (LOOP_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk   (clk),
    .cmd   (cmd),
    .addr  (addr),
    .wdata ({din.sample_left, din.sample_right}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset; the store read data holds while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      out_left_q  <= din.sample_left;
      out_right_q <= din.sample_right;
      out_looping <= cmd.rd_en;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.looping   = out_looping;
  assign dout.out_left  = out_looping ? $signed(rdata[asl_pkg::PAIR_W-1:asl_pkg::SAMPLE_W])
                                      : out_left_q;
  assign dout.out_right = out_looping ? $signed(rdata[asl_pkg::SAMPLE_W-1:0])
                                      : out_right_q;

endmodule

### design/asl_checker.sv
// ----------------------------------------------------------------------------
// asl_checker - port-level checks for the audio stutter loop unit
// Watches the two channels and checks item flow through the output stage.
// ----------------------------------------------------------------------------
module asl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [asl_pkg::SAMPLE_W-1:0] out_left,
  input logic signed [asl_pkg::SAMPLE_W-1:0] out_right,
  input logic                                looping
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left) &&
    $stable(out_right) && $stable(looping))
    else $error("stalled result changed");

  // Empty output stage never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  // Every accepted item gives a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // No result without an item behind it
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
    else $error("result repeated");

endmodule

bind audio_stutter_loop_unit asl_checker u_asl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_left  (dout.out_left),
  .out_right (dout.out_right),
  .looping   (dout.looping)
);
